[rtl/core/wiener_deconvolution_bin_top_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the Wiener deconvolution bin block
// Clocked property wrappers used by the port checker.
// ---------------------------------------------------------------------------
`ifndef WIENER_DECONVOLUTION_BIN_TOP_MACROS_SVH
`define WIENER_DECONVOLUTION_BIN_TOP_MACROS_SVH

// checked only outside reset
`define WDB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define WDB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/core/wdb_pkg.sv]
// ---------------------------------------------------------------------------
// wdb_pkg
// Widths, constants and cell types of the Wiener deconvolution bin block.
// ---------------------------------------------------------------------------
`default_nettype none
package wdb_pkg;
    localparam int KW    = 20;   // kernel component
    localparam int GW    = 32;   // image component
    localparam int CW    = 24;   // inv_snr register
    localparam int OW    = 48;   // result component
    localparam int DW    = 41;   // denominator
    localparam int MW    = 52;   // numerator magnitude
    localparam int QW    = 50;   // quotient bits = number of cells
    localparam int EPS_Q16 = 7;

    typedef struct packed {
        logic [DW-1:0] rem;
        logic [QW-1:0] sh;   // dividend bits out at top, quotient bits in at bottom
        logic          neg;
    } t_lane;

    typedef struct packed {
        logic          vld;
        logic [DW-1:0] den;
        t_lane         re;
        t_lane         im;
    } t_cell;
endpackage
`default_nettype wire

[rtl/core/wdb_front.sv]
// ---------------------------------------------------------------------------
// wdb_front
// Products, then denominator, numerator magnitudes and signs for the cells.
// ---------------------------------------------------------------------------
`default_nettype none
module wdb_front (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire logic                   i_vld,
    input  wire logic [19:0]            i_kernel_re,
    input  wire logic [19:0]            i_kernel_im,
    input  wire logic [31:0]            i_image_re,
    input  wire logic [31:0]            i_image_im,
    input  wire logic [23:0]            i_inv_snr,
    output wdb_pkg::t_cell              o_cell
);
    import wdb_pkg::*;

    logic                 r_vld_a;
    logic signed [39:0]   r_krr, r_kii;
    logic signed [51:0]   r_krgr, r_kigi, r_krgi, r_kigr;
    t_cell                r_cell;
    t_cell                n_cell;
    logic signed [52:0]   w_nre, w_nim;
    logic [52:0]          w_mre, w_mim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a      <= 1'b0;
            r_cell.vld   <= 1'b0;
        end else if (i_en) begin
            r_vld_a      <= i_vld;
            r_cell.vld   <= n_cell.vld;
        end
        if (i_en) begin
            r_krr  <= $signed(i_kernel_re) * $signed(i_kernel_re);
            r_kii  <= $signed(i_kernel_im) * $signed(i_kernel_im);
            r_krgr <= $signed(i_kernel_re) * $signed(i_image_re);
            r_kigi <= $signed(i_kernel_im) * $signed(i_image_im);
            r_krgi <= $signed(i_kernel_re) * $signed(i_image_im);
            r_kigr <= $signed(i_kernel_im) * $signed(i_image_re);
            r_cell.den <= n_cell.den;
            r_cell.re  <= n_cell.re;
            r_cell.im  <= n_cell.im;
        end
    end

    always_comb begin
        w_nre = 53'(r_krgr) + 53'(r_kigi);
        w_nim = 53'(r_krgi) - 53'(r_kigr);
        w_mre = w_nre[52] ? 53'(-w_nre) : 53'(w_nre);
        w_mim = w_nim[52] ? 53'(-w_nim) : 53'(w_nim);
        n_cell.vld = r_vld_a;
        // squares are non-negative, so 39 bits each
        n_cell.den = DW'(r_krr[38:0]) + DW'(r_kii[38:0])
                   + ((DW'(EPS_Q16) + DW'(i_inv_snr)) << 16);
        // dividend = mag << 16; its top 18 bits always fall below den
        n_cell.re.rem = DW'(w_mre[MW-1:34]);
        n_cell.re.sh  = {w_mre[33:0], 16'b0};
        n_cell.re.neg = w_nre[52];
        n_cell.im.rem = DW'(w_mim[MW-1:34]);
        n_cell.im.sh  = {w_mim[33:0], 16'b0};
        n_cell.im.neg = w_nim[52];
    end

    assign o_cell = r_cell;
endmodule
`default_nettype wire

[rtl/core/wdb_cell.sv]
// ---------------------------------------------------------------------------
// wdb_cell
// One restoring-division step for both lanes, registered.
// ---------------------------------------------------------------------------
`default_nettype none
module wdb_cell (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wdb_pkg::t_cell      i_cell,
    output wdb_pkg::t_cell      o_cell
);
    import wdb_pkg::*;

    t_cell r_cell;
    t_cell n_cell;

    function automatic t_lane step(input t_lane l, input logic [DW-1:0] den);
        logic [DW:0]   t;
        t_lane         o;
        t = {l.rem, l.sh[QW-1]};
        o = l;
        if (t >= {1'b0, den}) begin
            o.rem = DW'(t - {1'b0, den});
            o.sh  = {l.sh[QW-2:0], 1'b1};
        end else begin
            o.rem = t[DW-1:0];
            o.sh  = {l.sh[QW-2:0], 1'b0};
        end
        return o;
    endfunction

    always_comb begin
        n_cell     = i_cell;
        n_cell.re  = step(i_cell.re, i_cell.den);
        n_cell.im  = step(i_cell.im, i_cell.den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.vld <= 1'b0;
        end else if (i_en) begin
            r_cell.vld <= n_cell.vld;
        end
        if (i_en) begin
            r_cell.den <= n_cell.den;
            r_cell.re  <= n_cell.re;
            r_cell.im  <= n_cell.im;
        end
    end

    assign o_cell = r_cell;
endmodule
`default_nettype wire

[rtl/core/wiener_deconvolution_bin_top.sv]
// ---------------------------------------------------------------------------
// wiener_deconvolution_bin_top
// Wiener deconvolution of one frequency bin: conj(H)*G / (|H|^2+eps+inv_snr).
// ---------------------------------------------------------------------------
// Channel   Dir  Handshake                   Payload
// s_axis    in   i_s_tvalid / o_s_tready     kernel_re, kernel_im, image_re, image_im
// m_axis    out  o_m_tvalid / i_m_tready     restored_re, restored_im
// cfg       in   i_cfg_valid / o_cfg_ready   inv_snr (unsigned Q8.16)
//
// One bin per cycle sustained while results are taken. The pipeline is a multiply
// stage, a sum stage, 50 division cells (one quotient bit each), and the output register.
// The whole pipeline advances together; it stalls only when the output
// register holds a transaction that is not taken.
// Synchronous active-low reset clears all valid bits and sets inv_snr to 6554.
// ---------------------------------------------------------------------------
`default_nettype none
module wiener_deconvolution_bin_top (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // kernel_re[19:0], kernel_im[39:20], image_re[71:40], image_im[103:72]
    input  wire logic [103:0] i_s_tdata,
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // restored_re[47:0], restored_im[95:48]
    output logic [95:0]       o_m_tdata,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [23:0]  i_cfg_data
);
    import wdb_pkg::*;

    localparam logic [QW-1:0] POS_MAX = QW'({1'b0, {(OW-1){1'b1}}});

    logic               w_en;
    logic [CW-1:0]      r_inv_snr;
    t_cell              w_chain [0:QW];
    logic               r_out_vld;
    logic [OW-1:0]      r_out_re, r_out_im;

    // advance whenever the output slot is free or being emptied
    assign w_en       = !r_out_vld || i_m_tready;
    assign o_s_tready = w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_snr <= CW'(6554);
        end else if (i_cfg_valid) begin
            r_inv_snr <= i_cfg_data;
        end
    end

    wdb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_vld       (i_s_tvalid),
        .i_kernel_re (i_s_tdata[19:0]),
        .i_kernel_im (i_s_tdata[39:20]),
        .i_image_re  (i_s_tdata[71:40]),
        .i_image_im  (i_s_tdata[103:72]),
        .i_inv_snr   (r_inv_snr),
        .o_cell      (w_chain[0])
    );

    // divider: each cell resolves one quotient bit and hands on to the next
    for (genvar g = 0; g < QW; g++) begin : g_cell
        wdb_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_cell  (w_chain[g]),
            .o_cell  (w_chain[g+1])
        );
    end

    // sign restore and 48-bit saturation
    function automatic logic [OW-1:0] sat(input t_lane l);
        logic [OW-1:0] r;
        if (l.neg) begin
            if (l.sh > POS_MAX) r = {1'b1, {(OW-1){1'b0}}};
            else                r = OW'(-l.sh);
        end else begin
            if (l.sh > POS_MAX) r = {1'b0, {(OW-1){1'b1}}};
            else                r = OW'(l.sh);
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_chain[QW].vld;
        end
        if (w_en) begin
            r_out_re <= sat(w_chain[QW].re);
            r_out_im <= sat(w_chain[QW].im);
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {r_out_im, r_out_re};
endmodule
`default_nettype wire

[rtl/core/wdb_checker.sv]
// ---------------------------------------------------------------------------
// wdb_checker
// Port-level checks on the Wiener deconvolution bin block.
// ---------------------------------------------------------------------------
`default_nettype none
`include "wiener_deconvolution_bin_top_macros.svh"
module wdb_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         i_s_tready,
    input wire logic         i_m_tvalid,
    input wire logic         i_m_tready,
    input wire logic [95:0]  i_m_tdata,
    input wire logic         i_cfg_ready
);
    // a stalled result holds
    `WDB_ASSERT(a_hold, (i_m_tvalid && !i_m_tready) |=> (i_m_tvalid && $stable(i_m_tdata)), "result changed under stall")
    // a full, stalled output slot stops intake
    `WDB_ASSERT(a_backpr, (i_m_tvalid && !i_m_tready) |-> !i_s_tready, "input taken while output stalled")
    // nothing comes out right after reset
    `WDB_ASSERT_ALWAYS(a_rst, !i_rst_n |=> !i_m_tvalid, "valid result after reset")
    // a free output slot never blocks intake
    `WDB_ASSERT(a_free, !i_m_tvalid |-> (i_s_tready && i_cfg_ready), "block stalled while empty")
endmodule

bind wiener_deconvolution_bin_top wdb_checker u_wdb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_s_tready  (o_s_tready),
    .i_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .i_m_tdata   (o_m_tdata),
    .i_cfg_ready (o_cfg_ready)
);
`default_nettype wire
